FILE: sv/hfts_pkg.sv
package hfts_pkg;

  // Default number of grid points per side that the store is built for.
  localparam int GRID_SIDE_DEFAULT = 256;

  // One in Q16.16, wide enough to hold the full cell fraction.
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Function codes of an input item.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_GRID_ORIGIN      = 2'd0,
    CFG_INVERSE_SPACING  = 2'd1,
    CFG_GRID_SIDE_IN_USE = 2'd2
  } hfts_cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [31:0] GRID_ORIGIN_RESET      = 32'd0;
  localparam logic [31:0] INVERSE_SPACING_RESET  = 32'd65536;
  localparam logic [8:0]  GRID_SIDE_IN_USE_RESET = 9'd256;

  // Control that travels with every item from stage to stage.
  typedef struct packed {
    logic valid;   // stage holds an item
    logic query;   // item samples a height and yields a result
    logic wr_ok;   // write item whose index falls inside the store
  } hfts_ctl_t;

endpackage

FILE: sv/hfts_grid_map.sv
module hfts_grid_map #(
  parameter int  GRID_SIDE = hfts_pkg::GRID_SIDE_DEFAULT,
  localparam int DEPTH     = GRID_SIDE * GRID_SIDE,
  localparam int AW        = $clog2(DEPTH),
  localparam int IXW       = $clog2(GRID_SIDE),
  localparam int SW        = $clog2(GRID_SIDE + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic                    func,
  input  logic [15:0]             cell_index,
  input  logic [31:0]             height_value,
  input  logic [31:0]             query_x,
  input  logic [31:0]             query_z,
  input  logic [31:0]             grid_origin,
  input  logic [31:0]             inverse_spacing,
  input  logic [SW-1:0]           side,
  output hfts_pkg::hfts_ctl_t     out_ctl,
  output logic [AW-1:0]           wr_addr,
  output logic [31:0]             wr_data,
  output logic [AW-1:0]           row,
  output logic [16:0]             u,
  output logic [16:0]             v
);
  import hfts_pkg::*;

  localparam int GW = IXW + 16;

  hfts_ctl_t c1, c2, c3, c4;
  logic [AW-1:0] wa1, wa2, wa3, wa4;
  logic [31:0]   wd1, wd2, wd3, wd4;

  // Stage 1: offset from the grid corner.
  logic [32:0] dx1, dz1;
  // Stage 2: scaled grid coordinate, full precision.
  logic [63:0] px2, pz2;
  // Stage 3: grid coordinate clamped to the last grid point.
  logic [GW-1:0] gx3, gz3;
  // Stage 4: cell index and fraction within the cell.
  logic [IXW-1:0] ix4, iz4;
  logic [16:0]    u4, v4;

  logic            pos_x, pos_z;
  logic [GW-1:0]   top;
  logic [47:0]     gx_raw, gz_raw;
  logic [IXW-1:0]  lim, ix_raw, iz_raw, ix_c, iz_c;
  logic [GW-1:0]   ux, vz;
  logic [AW-1:0]   row_c;

  assign pos_x  = !dx1[32] && (|dx1[31:0]);
  assign pos_z  = !dz1[32] && (|dz1[31:0]);
  assign top    = {IXW'(side - SW'(1)), 16'd0};
  assign gx_raw = px2[63:16];
  assign gz_raw = pz2[63:16];
  assign lim    = IXW'(side - SW'(2));
  assign ix_raw = gx3[GW-1:16];
  assign iz_raw = gz3[GW-1:16];
  assign ix_c   = (ix_raw > lim) ? lim : ix_raw;
  assign iz_c   = (iz_raw > lim) ? lim : iz_raw;
  assign ux     = gx3 - {ix_c, 16'd0};
  assign vz     = gz3 - {iz_c, 16'd0};
  assign row_c  = AW'(iz4) * AW'(side) + AW'(ix4);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1      <= '0;
      c2      <= '0;
      c3      <= '0;
      c4      <= '0;
      out_ctl <= '0;
    end else if (en) begin
      c1.valid <= in_valid;
      c1.query <= (func == FUNC_SAMPLE);
      c1.wr_ok <= (32'(cell_index) < 32'(DEPTH));
      c2       <= c1;
      c3       <= c2;
      c4       <= c3;
      out_ctl  <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wa1     <= AW'(cell_index);
      wd1     <= height_value;
      dx1     <= {query_x[31], query_x} - {grid_origin[31], grid_origin};
      dz1     <= {query_z[31], query_z} - {grid_origin[31], grid_origin};

      wa2     <= wa1;
      wd2     <= wd1;
      px2     <= pos_x ? dx1[31:0] * inverse_spacing : 64'd0;
      pz2     <= pos_z ? dz1[31:0] * inverse_spacing : 64'd0;

      wa3     <= wa2;
      wd3     <= wd2;
      gx3     <= (gx_raw > 48'(top)) ? top : gx_raw[GW-1:0];
      gz3     <= (gz_raw > 48'(top)) ? top : gz_raw[GW-1:0];

      wa4     <= wa3;
      wd4     <= wd3;
      ix4     <= ix_c;
      iz4     <= iz_c;
      u4      <= ux[16:0];
      v4      <= vz[16:0];

      wr_addr <= wa4;
      wr_data <= wd4;
      row     <= row_c;
      u       <= u4;
      v       <= v4;
    end
  end

endmodule

FILE: sv/hfts_store.sv
module hfts_store #(
  parameter int  GRID_SIDE = hfts_pkg::GRID_SIDE_DEFAULT,
  localparam int DEPTH     = GRID_SIDE * GRID_SIDE,
  localparam int AW        = $clog2(DEPTH),
  localparam int SW        = $clog2(GRID_SIDE + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hfts_pkg::hfts_ctl_t in_ctl,
  input  logic [AW-1:0]       wr_addr,
  input  logic [31:0]         wr_data,
  input  logic [AW-1:0]       row,
  input  logic [SW-1:0]       side,
  input  logic [16:0]         in_u,
  input  logic [16:0]         in_v,
  output hfts_pkg::hfts_ctl_t out_ctl,
  output logic signed [31:0]  nl,
  output logic signed [31:0]  nr,
  output logic signed [31:0]  fl,
  output logic signed [31:0]  fr,
  output logic [16:0]         u,
  output logic [16:0]         v
);
  import hfts_pkg::*;

  // Two identical copies: the near copy serves the cell's own row, the far
  // copy the row above it, each with two read ports.
  logic [31:0] mem_near [DEPTH];
  logic [31:0] mem_far  [DEPTH];

  logic          wr_en;
  logic [AW-1:0] addr_nr, addr_fl, addr_fr;

  assign wr_en   = en && in_ctl.valid && !in_ctl.query && in_ctl.wr_ok;
  assign addr_nr = row + AW'(1);
  assign addr_fl = row + AW'(side);
  assign addr_fr = row + AW'(side) + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_near[wr_addr] <= wr_data;
    end
    if (en) begin
      nl <= mem_near[row];
      nr <= mem_near[addr_nr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_far[wr_addr] <= wr_data;
    end
    if (en) begin
      fl <= mem_far[addr_fl];
      fr <= mem_far[addr_fr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= in_u;
      v <= in_v;
    end
  end

endmodule

FILE: sv/hfts_interp.sv
module hfts_interp (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hfts_pkg::hfts_ctl_t in_ctl,
  input  logic signed [31:0]  nl,
  input  logic signed [31:0]  nr,
  input  logic signed [31:0]  fl,
  input  logic signed [31:0]  fr,
  input  logic [16:0]         u,
  input  logic [16:0]         v,
  output hfts_pkg::hfts_ctl_t out_ctl,
  output logic [31:0]         sampled_height,
  output logic                overflow
);
  import hfts_pkg::*;

  hfts_ctl_t c7, c8;

  logic signed [31:0] b7, b8;
  logic signed [32:0] d1, d2;
  logic [16:0]        w1, w2;
  logic signed [50:0] p1, p2;
  logic signed [51:0] t9;

  logic        lower;
  logic [35:0] r;

  // The lower triangle holds the corner at the cell origin.
  assign lower = ({1'b0, u} + {1'b0, v}) <= {1'b0, ONE_Q16};

  always_ff @(posedge clk) begin
    if (rst) begin
      c7      <= '0;
      c8      <= '0;
      out_ctl <= '0;
    end else if (en) begin
      c7      <= in_ctl;
      c8      <= c7;
      out_ctl <= c8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (lower) begin
        b7 <= nl;
        d1 <= 33'(nr) - 33'(nl);
        w1 <= u;
        d2 <= 33'(fl) - 33'(nl);
        w2 <= v;
      end else begin
        b7 <= fr;
        d1 <= 33'(fl) - 33'(fr);
        w1 <= ONE_Q16 - u;
        d2 <= 33'(nr) - 33'(fr);
        w2 <= ONE_Q16 - v;
      end
      b8 <= b7;
      p1 <= d1 * $signed({1'b0, w1});
      p2 <= d2 * $signed({1'b0, w2});
      t9 <= $signed({{4{b8[31]}}, b8, 16'd0}) + 52'(p1) + 52'(p2);
    end
  end

  // Dropping the low 16 bits of the two's complement sum rounds toward
  // minus infinity.
  assign r        = t9[51:16];
  assign overflow = (r[35:31] != 5'b00000) && (r[35:31] != 5'b11111);

  always_comb begin
    if (!overflow) begin
      sampled_height = r[31:0];
    end else if (r[35]) begin
      sampled_height = 32'h8000_0000;
    end else begin
      sampled_height = 32'h7fff_ffff;
    end
  end

endmodule

FILE: sv/heightfield_triangle_sample_top.sv
// A sample's result goes through stages 1 to 9 and the output register to m_axis_tvalid.
// Throughput: one item per cycle while the skid entry is empty. The pipeline and two dual-read
// store copies serve all four cell corners in the same cycle; a write item takes the same stages.
// A two-entry output buffer lets the pipeline keep moving while one result waits.
// Reset: rst is synchronous, active high; it clears all valid bits and sets the registers to
// their defaults. The height store is not cleared and holds nothing defined until written.
module heightfield_triangle_sample_top #(
  parameter int  GRID_SIDE = hfts_pkg::GRID_SIDE_DEFAULT,
  localparam int DEPTH     = GRID_SIDE * GRID_SIDE,
  localparam int AW        = $clog2(DEPTH),
  localparam int SW        = $clog2(GRID_SIDE + 1)
) (
  input  logic         clk,
  input  logic         rst,

  // Configuration write port.
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,

  // Input items.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0 up: cell_index[15:0], height_value[31:0], query_x[31:0], query_z[31:0].
  input  logic [111:0] s_axis_tdata,
  // Bit 0: func.
  input  logic         s_axis_tuser,

  // Result items.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0 up: sampled_height[31:0].
  output logic [31:0]  m_axis_tdata,
  // Bit 0: overflow.
  output logic         m_axis_tuser
);
  import hfts_pkg::*;

  // Configuration registers. The user must see that they are written only while no item
  // is in flight, so the stages read them directly; the block itself does not enforce it.
  logic [31:0] grid_origin;
  logic [31:0] inverse_spacing;
  logic [8:0]  grid_side_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_origin      <= GRID_ORIGIN_RESET;
      inverse_spacing  <= INVERSE_SPACING_RESET;
      grid_side_in_use <= GRID_SIDE_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_ORIGIN:      grid_origin      <= cfg_data;
        CFG_INVERSE_SPACING:  inverse_spacing  <= cfg_data;
        CFG_GRID_SIDE_IN_USE: grid_side_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // The side in use is clamped to what the store was built for, and never
  // below one cell.
  logic [SW-1:0] side_eff;

  always_comb begin
    if (32'(grid_side_in_use) < 32'd2) begin
      side_eff = SW'(2);
    end else if (32'(grid_side_in_use) > 32'(GRID_SIDE)) begin
      side_eff = SW'(GRID_SIDE);
    end else begin
      side_eff = SW'(grid_side_in_use);
    end
  end

  // The whole pipeline advances together. It stops only while the second
  // output entry is occupied, so one finished result can wait at the port
  // without holding back new items.
  logic en;
  logic out_valid, skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // Stages 1 to 5: coordinate to cell, fraction within the cell, and the
  // row-major index of the cell's origin corner.
  hfts_ctl_t     map_ctl;
  logic [AW-1:0] map_wr_addr, map_row;
  logic [31:0]   map_wr_data;
  logic [16:0]   map_u, map_v;

  hfts_grid_map #(.GRID_SIDE(GRID_SIDE)) u_grid_map (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_axis_tvalid),
    .func            (s_axis_tuser),
    .cell_index      (s_axis_tdata[15:0]),
    .height_value    (s_axis_tdata[47:16]),
    .query_x         (s_axis_tdata[79:48]),
    .query_z         (s_axis_tdata[111:80]),
    .grid_origin     (grid_origin),
    .inverse_spacing (inverse_spacing),
    .side            (side_eff),
    .out_ctl         (map_ctl),
    .wr_addr         (map_wr_addr),
    .wr_data         (map_wr_data),
    .row             (map_row),
    .u               (map_u),
    .v               (map_v)
  );

  // Stage 6: height store. Writes land here in item order, so a sample
  // that follows a write always sees it.
  hfts_ctl_t          st_ctl;
  logic signed [31:0] st_nl, st_nr, st_fl, st_fr;
  logic [16:0]        st_u, st_v;

  hfts_store #(.GRID_SIDE(GRID_SIDE)) u_store (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (map_ctl),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .row     (map_row),
    .side    (side_eff),
    .in_u    (map_u),
    .in_v    (map_v),
    .out_ctl (st_ctl),
    .nl      (st_nl),
    .nr      (st_nr),
    .fl      (st_fl),
    .fr      (st_fr),
    .u       (st_u),
    .v       (st_v)
  );

  // Stages 7 to 9: triangle choice, weighted corner differences, the sum,
  // and saturation to 32 bits.
  hfts_ctl_t   ip_ctl;
  logic [31:0] ip_height;
  logic        ip_ovf;

  hfts_interp u_interp (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_ctl         (st_ctl),
    .nl             (st_nl),
    .nr             (st_nr),
    .fl             (st_fl),
    .fr             (st_fr),
    .u              (st_u),
    .v              (st_v),
    .out_ctl        (ip_ctl),
    .sampled_height (ip_height),
    .overflow       (ip_ovf)
  );

  // Output buffer: the output register and one skid entry behind it. Only
  // sample items produce a result; write items end in the store.
  logic        res_valid;
  logic        out_taken;
  logic        load_out_res, load_out_skid, load_skid;
  logic [31:0] out_height, skid_height;
  logic        out_ovf, skid_ovf;

  assign res_valid     = en && ip_ctl.valid && ip_ctl.query;
  assign out_taken     = out_valid && m_axis_tready;
  assign load_out_skid = out_taken && skid_valid;
  assign load_out_res  = res_valid && (!out_valid || out_taken);
  assign load_skid     = res_valid && out_valid && !out_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
      if (load_out_skid || load_out_res) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      out_height <= skid_height;
      out_ovf    <= skid_ovf;
    end else if (load_out_res) begin
      out_height <= ip_height;
      out_ovf    <= ip_ovf;
    end
    if (load_skid) begin
      skid_height <= ip_height;
      skid_ovf    <= ip_ovf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_height;
  assign m_axis_tuser  = out_ovf;

  // The skid entry is only ever filled behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  // A result that meets a stalled output register must land in the skid entry.
  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && !m_axis_tready) |=> (skid_valid && out_valid))
    else $error("result dropped while the output was stalled");

  // Once the output is taken, the skid entry moves forward and empties.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m_axis_tready && skid_valid) |=> (out_valid && !skid_valid))
    else $error("skid entry did not move to the output register");

endmodule

FILE: tb/tb.sv
module tb;
  import hfts_pkg::*;

  localparam int     GRID       = GRID_SIDE_DEFAULT;
  localparam int     CELLS      = GRID * GRID;
  localparam longint Q_ONE      = longint'(ONE_Q16);
  // The run is aborted after this many time units (clock period is 10).
  localparam longint RUN_LIMIT  = 64'd4_000_000;
  // Register index that the block has no register behind.
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  // Cycles the receiver holds off while the sender keeps offering items.
  localparam int     HOLD_CYCLES = 300;
  localparam int     N_PHASES   = 9;
  localparam int     N_DIRECTED = 18;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;

  heightfield_triangle_sample_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // One expected result item: the interpolated height and its saturation flag.
  typedef struct packed {
    logic [31:0] height;
    logic        ovf;
  } height_result_t;

  // Where a sample point lands: the corner index of its cell, the side in
  // effect, and the Q16.16 fractions within the cell.
  typedef struct {
    int unsigned row;
    int unsigned side;
    longint      u;
    longint      v;
  } cell_loc_t;

  // A row of the directed table. Rows with has_exp set carry a result that
  // can be read off directly; the others are checked against the predictor.
  typedef struct packed {
    logic        func;
    logic [15:0] widx;
    logic [31:0] hval;
    logic [31:0] qx;
    logic [31:0] qz;
    logic        has_exp;
    logic [31:0] exp_height;
  } directed_row_t;

  // One configuration setting of the run, with its idling pattern.
  // rand_cfg: 0 = fixed values below, 1 = moderate random, 2 = any value.
  typedef struct packed {
    logic [31:0] origin;
    logic [31:0] inv;
    logic [8:0]  side;
    logic [1:0]  rand_cfg;
    int          src_idle;
    int          sink_stall;
    int          items;
    logic        pressure;
  } phase_t;

  // The directed part runs under the reset configuration: one world unit is
  // one cell, the origin is zero and the full 256 by 256 grid is in use.
  directed_row_t directed_rows [N_DIRECTED] = '{
    // Extreme heights around the first cell.
    '{FUNC_WRITE,  16'd0,     32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_WRITE,  16'd1,     32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_WRITE,  16'd256,   32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_WRITE,  16'd257,   32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0},
    // Exactly on the grid corner, the corner height comes back unchanged.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    // Below the origin on both axes the point snaps to the corner.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'hFFFB_0000, 32'hFF9C_0000, 1'b1, 32'h7FFF_FFFF},
    // On the diagonal the result is the mean of the two off-diagonal corners.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h0000_8000, 32'h0000_8000, 1'b1, 32'hC000_0000},
    // Upper triangle inside the first cell.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h0000_C000, 32'h0000_8000, 1'b0, 32'h0},
    // Next cell over; its missing corners get written first.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0},
    // The last cell of the grid.
    '{FUNC_WRITE,  16'd65278, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_WRITE,  16'd65279, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_WRITE,  16'd65534, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_WRITE,  16'd65535, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0},
    // Far beyond the grid the fractions reach one and the far corner wins.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h1234_5678},
    // Most negative x with most positive z.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
    // Overwrite a corner and read it back on the very next item.
    '{FUNC_WRITE,  16'd0,     32'h0000_8000, 32'h0, 32'h0, 1'b0, 32'h0},
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_8000},
    // On the last grid line in x, half way up the last row in z.
    '{FUNC_SAMPLE, 16'd0, 32'h0, 32'h00FF_0000, 32'h00FE_8000, 1'b0, 32'h0}
  };

  // Settings of the run. Phase 0 keeps the reset values; the others cover
  // the extremes of each register, values the block must clamp, a zero
  // spacing reciprocal and random settings.
  phase_t phases [N_PHASES] = '{
    '{32'h0000_0000, 32'h0001_0000, 9'd256, 2'd0,  0,  0, 200, 1'b0},
    '{32'hFFFD_0000, 32'h0002_0000, 9'd16,  2'd0, 85,  0, 150, 1'b0},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd2,   2'd0,  0, 85,  80, 1'b0},
    '{32'h8000_0000, 32'h0000_0001, 9'd511, 2'd0, 38, 38, 100, 1'b0},
    '{32'h0005_4321, 32'h0000_0000, 9'd0,   2'd0,  0,  0,  60, 1'b1},
    '{32'h0010_0000, 32'h0000_4000, 9'd100, 2'd0, 85,  0, 100, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 9'd0,   2'd1,  0, 85, 120, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 9'd0,   2'd2, 38, 38, 120, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 9'd0,   2'd1,  0,  0, 100, 1'b1}
  };

  // Predictor state: its own copy of the registers and of the height store,
  // plus a mask of the entries written so far so that no sample ever reads
  // an entry that holds nothing defined.
  logic signed [31:0] cfg_origin = GRID_ORIGIN_RESET;
  logic        [31:0] cfg_inv    = INVERSE_SPACING_RESET;
  logic        [8:0]  cfg_side   = GRID_SIDE_IN_USE_RESET;
  logic signed [31:0] height_mem [CELLS];
  bit                 entry_written [CELLS];

  // Results the block still owes, oldest first.
  height_result_t pending_heights [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_ticket    = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int n_writes       = 0;
  int n_samples      = 0;
  int n_sent         = 0;
  int n_results      = 0;
  int n_mismatch     = 0;
  int n_settings     = 1;
  int n_holds        = 0;

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned side_in_effect();
    int unsigned s;
    s = cfg_side;
    if (s < 2) s = 2;
    if (s > GRID) s = GRID;
    return s;
  endfunction

  // World coordinate to grid coordinate in Q16.16, clamped to the grid.
  function automatic logic [63:0] grid_position(logic [31:0] coord, int unsigned side);
    longint      d;
    logic [63:0] du;
    logic [63:0] g;
    logic [63:0] top;
    d   = longint'($signed(coord)) - longint'(cfg_origin);
    top = 64'(side - 1) << 16;
    if (d <= 0) return 64'd0;
    du = d;
    g  = (du * {32'd0, cfg_inv}) >> 16;
    return (g > top) ? top : g;
  endfunction

  function automatic cell_loc_t locate_cell(logic [31:0] qx, logic [31:0] qz);
    cell_loc_t   loc;
    logic [63:0] gx;
    logic [63:0] gz;
    int unsigned ix;
    int unsigned iz;
    loc.side = side_in_effect();
    gx = grid_position(qx, loc.side);
    gz = grid_position(qz, loc.side);
    ix = 32'(gx >> 16);
    iz = 32'(gz >> 16);
    // The cell index stops one short of the last grid line.
    if (ix > loc.side - 2) ix = loc.side - 2;
    if (iz > loc.side - 2) iz = loc.side - 2;
    loc.u   = longint'(gx) - (longint'(ix) << 16);
    loc.v   = longint'(gz) - (longint'(iz) << 16);
    loc.row = iz * loc.side + ix;
    return loc;
  endfunction

  // Planar interpolation over the lower or upper triangle of the cell.
  function automatic height_result_t interpolate_height(cell_loc_t loc);
    height_result_t res;
    longint nl;
    longint nr;
    longint fl;
    longint fr;
    longint t;
    longint r;
    nl = longint'(height_mem[loc.row]);
    nr = longint'(height_mem[loc.row + 1]);
    fl = longint'(height_mem[loc.row + loc.side]);
    fr = longint'(height_mem[loc.row + loc.side + 1]);
    if (loc.u + loc.v <= Q_ONE)
      t = nl * Q_ONE + (nr - nl) * loc.u + (fl - nl) * loc.v;
    else
      t = fr * Q_ONE + (fl - fr) * (Q_ONE - loc.u) + (nr - fr) * (Q_ONE - loc.v);
    // Arithmetic shift rounds toward minus infinity.
    r = t >>> 16;
    res.ovf = 1'b0;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.ovf = 1'b1;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.ovf = 1'b1;
    end
    res.height = r[31:0];
    return res;
  endfunction

  function automatic logic [31:0] random_height();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
  endfunction

  // Pick a world coordinate: mostly inside the grid, some at either edge,
  // some anywhere in the 32-bit range.
  function automatic logic [31:0] pick_coord();
    longint span;
    longint off;
    longint c;
    logic [63:0] raw;
    if (cfg_inv == 0)
      span = 262144;
    else
      span = (longint'(side_in_effect() - 1) << 32) / longint'({32'd0, cfg_inv});
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return $urandom;
      1:       off = longint'($urandom_range(0, 262144)) - 131072;
      2:       off = span + longint'($urandom_range(0, 262144)) - 131072;
      default: off = longint'(raw % 64'(span + 1));
    endcase
    c = longint'(cfg_origin) + off;
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c[31:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
  endtask

  // Offer one item and wait for it to be accepted. The predictor is updated
  // at the accepting edge, so the order of expectations follows acceptance.
  task automatic send_item(input logic func, input logic [15:0] widx,
                           input logic [31:0] hval, input logic [31:0] qx,
                           input logic [31:0] qz, input logic has_exp,
                           input logic [31:0] exp_height);
    height_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qz, qx, hval, widx};
    s_axis_tuser  <= func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
    if (func == FUNC_WRITE) begin
      height_mem[widx]    = hval;
      entry_written[widx] = 1'b1;
      n_writes++;
    end else begin
      if (has_exp)
        res = '{exp_height, 1'b0};
      else
        res = interpolate_height(locate_cell(qx, qz));
      pending_heights.push_back(res);
      n_samples++;
    end
  endtask

  // Write any corner of the sample's cell that has never been written.
  task automatic fill_corners(input logic [31:0] qx, input logic [31:0] qz);
    cell_loc_t   loc;
    int unsigned idx [4];
    loc = locate_cell(qx, qz);
    idx = '{loc.row, loc.row + 1, loc.row + loc.side, loc.row + loc.side + 1};
    foreach (idx[k]) begin
      if (!entry_written[idx[k]])
        send_item(FUNC_WRITE, idx[k][15:0], random_height(), $urandom, $urandom, 1'b0, '0);
    end
  endtask

  task automatic sample_at(input logic [31:0] qx, input logic [31:0] qz,
                           input logic has_exp, input logic [31:0] exp_height);
    fill_corners(qx, qz);
    send_item(FUNC_SAMPLE, 16'($urandom), $urandom, qx, qz, has_exp, exp_height);
  endtask

  // Drive one register write; the caller lowers the enable after a batch.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_GRID_ORIGIN:      cfg_origin = val;
      CFG_INVERSE_SPACING:  cfg_inv    = val;
      CFG_GRID_SIDE_IN_USE: cfg_side   = val[8:0];
      default: ;
    endcase
  endtask

  // Stop offering, let every owed result come out, then give the pipeline
  // time to drain trailing write items.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Receiver: random stalls, a long hold-off on request, and the checker.
  always @(posedge clk) begin
    height_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pending_heights.size() == 0) begin
          note_mismatch("result with nothing owed, sampled_height", '0, m_axis_tdata);
        end else begin
          want = pending_heights.pop_front();
          if (m_axis_tdata !== want.height)
            note_mismatch("sampled_height", want.height, m_axis_tdata);
          if (m_axis_tuser !== want.ovf)
            note_mismatch("overflow", {31'd0, want.ovf}, {31'd0, m_axis_tuser});
        end
      end
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Main sequence: reset, the directed table, then one random part per
  // setting, with the registers rewritten only while the block is idle.
  initial begin
    phase_t        ph;
    directed_row_t dr;
    logic [31:0]   qx;
    logic [31:0]   qz;
    logic [31:0]   wcell_span;
    int            drain;
    int            phase_start;
    foreach (entry_written[k]) entry_written[k] = 1'b0;
    foreach (height_mem[k]) height_mem[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration, back to back.
    for (int i = 0; i < N_DIRECTED; i++) begin
      dr = directed_rows[i];
      if (dr.func == FUNC_WRITE)
        send_item(FUNC_WRITE, dr.widx, dr.hval, dr.qx, dr.qz, 1'b0, '0);
      else
        sample_at(dr.qx, dr.qz, dr.has_exp, dr.exp_height);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      ph = phases[p];
      if (p > 0) begin
        wait_idle();
        case (ph.rand_cfg)
          2'd1: begin
            ph.origin = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            ph.inv    = $urandom_range(32'h0000_0800, 32'h0008_0000);
            ph.side   = 9'($urandom_range(2, 256));
          end
          2'd2: begin
            ph.origin = $urandom;
            ph.inv    = $urandom;
            ph.side   = 9'($urandom_range(0, 511));
          end
          default: ;
        endcase
        // A write to the index with no register behind it must change nothing.
        if (p == 2) write_reg(CFG_UNUSED_IDX, $urandom);
        write_reg(CFG_GRID_ORIGIN, ph.origin);
        write_reg(CFG_INVERSE_SPACING, ph.inv);
        // Bits above the register width are set at random; only nine are kept.
        write_reg(CFG_GRID_SIDE_IN_USE, {23'($urandom_range(0, 32'h007F_FFFF)), ph.side});
        cfg_wr_en <= 1'b0;
        n_settings++;
      end
      src_idle_pct    = ph.src_idle;
      sink_stall_pct <= ph.sink_stall;
      if (ph.pressure) begin
        // The receiver stops for a long stretch while items keep coming, so
        // the output buffer and the pipeline fill and the input must stall.
        hold_ticket <= hold_ticket + 1;
        n_holds++;
      end
      wcell_span = side_in_effect() * side_in_effect() - 1;
      // The corner writes that precede a sample count toward the phase's items.
      phase_start = n_sent;
      while (n_sent - phase_start < ph.items) begin
        if ($urandom_range(99) < 20) begin
          send_item(FUNC_WRITE,
                    $urandom_range(1) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, wcell_span)),
                    random_height(), $urandom, $urandom, 1'b0, '0);
        end else begin
          qx = pick_coord();
          qz = pick_coord();
          sample_at(qx, qz, 1'b0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (pending_heights.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    if (pending_heights.size() != 0) begin
      $display("%0d expected results never arrived", pending_heights.size());
      n_mismatch += pending_heights.size();
    end
    // Leave time for any stray result to show up and be flagged.
    repeat (20) @(posedge clk);

    $display("Covered %0d height writes and %0d samples over %0d register settings,",
             n_writes, n_samples, n_settings);
    $display("with %0d long receiver hold-offs; %0d results compared, %0d mismatches.",
             n_holds, n_results, n_mismatch);
    if (n_mismatch == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: heightfield_triangle_sample_top.f
sv/hfts_pkg.sv
sv/hfts_grid_map.sv
sv/hfts_store.sv
sv/hfts_interp.sv
sv/heightfield_triangle_sample_top.sv
tb/tb.sv
